/* hw/rtl/lrufr_pkg.sv */
// ----------------------------------------------------------------------------
// lrufr_pkg
// Shared sizes, codes and types for the LRU frame replacement block.
// ----------------------------------------------------------------------------
package lrufr_pkg;

   localparam int FRAME_COUNT = 32;
   localparam int FRAME_W     = 5;
   localparam int SCORE_W     = 16;
   localparam int TDATA_W     = 8;

   localparam int IDX_W  = $clog2(FRAME_COUNT);
   localparam int USED_W = $clog2(FRAME_COUNT + 1);
   localparam int CMP_W  = (USED_W > FRAME_W) ? USED_W : FRAME_W;
   localparam int CNT_W  = IDX_W;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sd32767;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = -16'sd32767;
   localparam logic signed [SCORE_W-1:0] SCORE_ONE = 16'sd1;

   localparam logic MODE_TOUCH = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EVICT
   } state_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic             touch_en;
      logic             evict;
      logic [CMP_W-1:0] frame;
      logic [CMP_W-1:0] used;
   } cell_cmd_type;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [IDX_W-1:0]          idx;
   } min_tok_type;

endpackage

/* hw/rtl/lrufr_cell.sv */
// ----------------------------------------------------------------------------
// lrufr_cell
// One frame slot: holds its score, applies touches, and passes the running
// minimum on to the next cell through a register.
// ----------------------------------------------------------------------------
module lrufr_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lrufr_pkg::CMP_W-1:0]     cell_idx,
   input  lrufr_pkg::cell_cmd_type         cmd,
   input  lrufr_pkg::min_tok_type          prev_tok,
   output lrufr_pkg::min_tok_type          next_tok
);
   import lrufr_pkg::*;

   logic signed [SCORE_W-1:0] score_ff;
   logic signed [SCORE_W-1:0] score_in;
   min_tok_type               min_ff;
   min_tok_type               min_in;
   logic                      hit;
   logic                      in_use;

   assign hit    = (cmd.frame == cell_idx);
   assign in_use = (cell_idx < cmd.used);

   always_comb begin
      score_in = score_ff;
      if (cmd.touch_en && in_use) begin
         if (hit) begin
            // evicted frame restarts at zero, then takes its touch
            if (cmd.evict) begin
               score_in = SCORE_ONE;
            end else if (score_ff != SCORE_MAX) begin
               score_in = score_ff + SCORE_ONE;
            end
         end else if (score_ff != SCORE_MIN) begin
            score_in = score_ff - SCORE_ONE;
         end
      end
   end

   // strict less-than keeps the lower index on ties
   always_comb begin
      if ($signed(score_ff) < $signed(prev_tok.score)) begin
         min_in.score = score_ff;
         min_in.idx   = cell_idx[IDX_W-1:0];
      end else begin
         min_in = prev_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
      end else begin
         score_ff <= score_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
   end

   assign next_tok = min_ff;

endmodule

/* hw/rtl/lrufr_chain.sv */
// ----------------------------------------------------------------------------
// lrufr_chain
// Row of frame cells. Touch commands reach all cells at once; the minimum
// search ripples one cell per cycle toward the far end.
// ----------------------------------------------------------------------------
module lrufr_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  lrufr_pkg::cell_cmd_type  cmd,
   output lrufr_pkg::min_tok_type   victim
);
   import lrufr_pkg::*;

   min_tok_type tok [FRAME_COUNT+1];

   // seed: any score beats it except the ceiling, which then resolves to frame 0
   assign tok[0] = '{score: SCORE_MAX, idx: '0};

   for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
      lrufr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (CMP_W'(i)),
         .cmd      (cmd),
         .prev_tok (tok[i]),
         .next_tok (tok[i+1])
      );
   end

   assign victim = tok[FRAME_COUNT];

endmodule

/* hw/rtl/lru_frame_replacement.sv */
// ----------------------------------------------------------------------------
// lru_frame_replacement
// Counter-based LRU choice of physical frames over a row of score cells.
// ----------------------------------------------------------------------------
// Input beats arrive on req_*: req_tuser picks touch (0) or allocate (1),
// req_tdata carries the frame to touch. Each input beat yields exactly one
// result beat on rsp_*: the frame touched or handed out, and in rsp_tuser
// a flag that is set when an allocation evicted an occupied frame.
// Touches and allocations of a still-unused frame update every cell at once;
// the result shows in the cycle after the beat is taken, and such beats can
// follow each other every cycle while the receiver keeps up.
// An allocation with all frames in use runs the minimum search down the
// cell row, one cell per cycle, in ST_SEARCH; ST_EVICT then evicts and
// touches the victim and loads the result once the output register is free.
// No input beat is taken during the search.
// The result sits in an output register; a new beat is taken while it waits
// only if the receiver takes the old one in the same cycle. A stalled
// receiver therefore holds off the input side.
// Reset clears all scores, the count of frames in use and the result valid flag.
// ----------------------------------------------------------------------------
module lru_frame_replacement (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lrufr_pkg::TDATA_W-1:0]     req_tdata,   // [4:0] frame_in
   input  logic                              req_tuser,   // [0] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lrufr_pkg::TDATA_W-1:0]     rsp_tdata,   // [4:0] frame_out
   output logic                              rsp_tuser    // [0] evicted
);
   import lrufr_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [USED_W-1:0]  used_ff;
   logic [USED_W-1:0]  used_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               rsp_valid_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [FRAME_W-1:0] rsp_frame_in;
   logic               rsp_evicted_ff;
   logic               rsp_evicted_in;
   logic               rsp_load;
   logic               slot_free;
   logic               accept;
   logic               full;
   logic [FRAME_W-1:0] frame_in;
   cell_cmd_type       cmd;
   min_tok_type        victim;

   assign frame_in  = req_tdata[FRAME_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   assign full      = (used_ff == USED_W'(FRAME_COUNT));

   lrufr_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .victim (victim)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == MODE_ALLOC) && full) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (cnt_ff == CNT_W'(FRAME_COUNT - 1)) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      used_in        = used_ff;
      cnt_in         = cnt_ff;
      rsp_load       = 1'b0;
      rsp_frame_in   = rsp_frame_ff;
      rsp_evicted_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = slot_free;
            if (accept) begin
               if (req_tuser == MODE_TOUCH) begin
                  cmd.touch_en = 1'b1;
                  cmd.frame    = CMP_W'(frame_in);
                  cmd.used     = CMP_W'(used_ff);
                  rsp_load     = 1'b1;
                  rsp_frame_in = frame_in;
               end else if (!full) begin
                  // hand out the next fresh frame; it counts as in use for its touch
                  used_in      = used_ff + 1'b1;
                  cmd.touch_en = 1'b1;
                  cmd.frame    = CMP_W'(used_ff);
                  cmd.used     = CMP_W'(used_in);
                  rsp_load     = 1'b1;
                  rsp_frame_in = FRAME_W'(used_ff);
               end else begin
                  cnt_in = '0;
               end
            end
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + 1'b1;
         end
         ST_EVICT: begin
            if (slot_free) begin
               cmd.touch_en   = 1'b1;
               cmd.evict      = 1'b1;
               cmd.frame      = CMP_W'(victim.idx);
               cmd.used       = CMP_W'(used_ff);
               rsp_load       = 1'b1;
               rsp_frame_in   = FRAME_W'(victim.idx);
               rsp_evicted_in = 1'b1;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_ff   <= rsp_frame_in;
         rsp_evicted_ff <= rsp_evicted_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_frame_ff);
   assign rsp_tuser  = rsp_evicted_ff;

endmodule

/* hw/rtl/lrufr_checker.sv */
// ----------------------------------------------------------------------------
// lrufr_checker
// Port-level checks for the LRU frame replacement block, bound to the top.
// ----------------------------------------------------------------------------
module lrufr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [lrufr_pkg::TDATA_W-1:0]  req_tdata,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lrufr_pkg::TDATA_W-1:0]  rsp_tdata,
   input logic                           rsp_tuser
);
   import lrufr_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // a touch beat answers in the next cycle, echoing its frame, never evicting
   a_touch_echo: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_TOUCH) |=>
         rsp_tvalid && !rsp_tuser &&
         (rsp_tdata[FRAME_W-1:0] == $past(req_tdata[FRAME_W-1:0])))
      else $error("touch result wrong or late");

   // no input taken while an unread result would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("input taken over a stalled result");

   // output channel is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind lru_frame_replacement lrufr_checker u_lrufr_checker (.*);
